@@ rtl/dcs_pkg.sv @@
// Package for the descriptor checksum engine: types, tables and polymod helpers.
package dcs_pkg;

  localparam int POLY_W   = 40;
  localparam int SYM_W    = 5;
  localparam int POS_W    = 7;
  localparam int IN_LEN   = 95;
  localparam int CK_LEN   = 32;
  localparam int CHAR_W   = 8;
  localparam int NUM_SYMS = 8;

  localparam logic [POLY_W-1:0] POLY_ONE = 40'd1;

  localparam logic [POLY_W-1:0] GEN [SYM_W] = '{
    40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d,
    40'h3706b1677a, 40'h644d626ffd
  };

  // First character sits in the top byte.
  localparam logic [IN_LEN*CHAR_W-1:0] IN_SET =
    {"0123456789()[],'/*abcdefgh@:$%{}",
     "IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~",
     "ijklmnopqrstuvwxyzABCDEFGH`#\"\\ "};

  localparam logic [CK_LEN*CHAR_W-1:0] CK_ALPHA = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } dcs_lookup_t;

  // Snapshot handed from the core to the emitter on a finish item.
  typedef struct packed {
    logic              valid;
    logic              bad;
    logic [POLY_W-1:0] poly;
  } dcs_fin_t;

  function automatic logic [POLY_W-1:0] pm_step(input logic [POLY_W-1:0] acc,
                                                input logic [SYM_W-1:0]  sym);
    logic [POLY_W-1:0] r;
    r = {acc[POLY_W-SYM_W-1:0], {SYM_W{1'b0}}} ^ {{(POLY_W-SYM_W){1'b0}}, sym};
    for (int b = 0; b < SYM_W; b++) begin
      if (acc[POLY_W-SYM_W+b]) r = r ^ GEN[b];
    end
    return r;
  endfunction

  function automatic dcs_lookup_t lookup_pos(input logic [CHAR_W-1:0] code);
    dcs_lookup_t res;
    res = '0;
    for (int i = 0; i < IN_LEN; i++) begin
      if (code == IN_SET[(IN_LEN-1-i)*CHAR_W +: CHAR_W]) begin
        res.hit = 1'b1;
        res.pos = POS_W'(i);
      end
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] ck_char(input logic [SYM_W-1:0] sym);
    return CK_ALPHA[{~sym, 3'b000} +: CHAR_W];
  endfunction

endpackage

@@ rtl/dcs_core.sv @@
// Character path: lookup, polymod and group packing state, finish snapshot.
module dcs_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_op,
  input  logic [7:0]              in_code,
  input  logic                    fin_ready,
  output logic                    consume,
  output dcs_pkg::dcs_fin_t       fin
);
  import dcs_pkg::*;

  logic [POLY_W-1:0] poly_acc, poly_acc_next;
  logic [SYM_W-1:0]  group_acc, group_acc_next;
  logic [1:0]        group_count, group_count_next;
  logic              bad_char_seen, bad_char_seen_next;

  dcs_lookup_t       lk;
  logic [POLY_W-1:0] p1;
  logic [SYM_W-1:0]  g_new;

  always_comb begin
    lk    = lookup_pos(in_code);
    p1    = pm_step(poly_acc, lk.pos[SYM_W-1:0]);
    g_new = {group_acc[SYM_W-2:0], 1'b0} + group_acc + {3'b000, lk.pos[POS_W-1:SYM_W]};

    consume = in_valid && (!in_op || fin_ready);

    fin.valid = in_valid && in_op && fin_ready;
    fin.bad   = bad_char_seen;
    fin.poly  = (group_count != 2'd0) ? pm_step(poly_acc, group_acc) : poly_acc;

    poly_acc_next      = poly_acc;
    group_acc_next     = group_acc;
    group_count_next   = group_count;
    bad_char_seen_next = bad_char_seen;

    if (consume) begin
      if (in_op) begin
        poly_acc_next      = POLY_ONE;
        group_acc_next     = '0;
        group_count_next   = '0;
        bad_char_seen_next = 1'b0;
      end else if (!lk.hit) begin
        bad_char_seen_next = 1'b1;
      end else if (group_count == 2'd2) begin
        poly_acc_next    = pm_step(p1, g_new);
        group_acc_next   = '0;
        group_count_next = '0;
      end else begin
        poly_acc_next    = p1;
        group_acc_next   = g_new;
        group_count_next = group_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_acc      <= POLY_ONE;
      group_acc     <= '0;
      group_count   <= '0;
      bad_char_seen <= 1'b0;
    end else begin
      poly_acc      <= poly_acc_next;
      group_acc     <= group_acc_next;
      group_count   <= group_count_next;
      bad_char_seen <= bad_char_seen_next;
    end
  end

endmodule

@@ rtl/dcs_emit.sv @@
// Finish path: eight zero steps, then the result items; a bad finish goes straight to one error item.
module dcs_emit (
  input  logic              clk,
  input  logic              rst,
  input  dcs_pkg::dcs_fin_t fin,
  output logic              fin_ready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);
  import dcs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

  state_t            state;
  logic [POLY_W-1:0] c;
  logic              err;
  logic [2:0]        cnt;
  logic              slot_free;
  logic              emit_last;
  logic [POLY_W-1:0] c2;

  assign fin_ready = (state == ST_IDLE);
  assign slot_free = !m_tvalid || m_tready;
  assign emit_last = err || (cnt == 3'(NUM_SYMS - 1));
  assign c2        = pm_step(pm_step(c, '0), '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      // in ST_EMIT the output slot is refilled below whenever it drains
      if (m_tready && state != ST_EMIT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (fin.valid) begin
            c     <= fin.poly;
            err   <= fin.bad;
            cnt   <= '0;
            state <= fin.bad ? ST_EMIT : ST_CALC;
          end
        end
        ST_CALC: begin
          // two zero steps per cycle, final xor of one on the last pass
          c   <= (cnt == 3'd3) ? (c2 ^ POLY_ONE) : c2;
          cnt <= (cnt == 3'd3) ? 3'd0 : cnt + 3'd1;
          if (cnt == 3'd3) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= err ? 8'd0 : ck_char(c[POLY_W-1 -: SYM_W]);
            m_tuser  <= err;
            m_tlast  <= emit_last;
            c        <= {c[POLY_W-SYM_W-1:0], {SYM_W{1'b0}}};
            cnt      <= cnt + 3'd1;
            if (emit_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("error item malformed");
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    fin.valid |=> state != ST_IDLE)
    else $error("finish snapshot not taken");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule

@@ rtl/descriptor_checksum_engine.sv @@
// Top level of the descriptor checksum engine: input register, core and emitter.
// Character items: one per cycle unless a finish item waits in the input register; each
//   passes from the input register into the polymod and group state.
// Finish items: loaded from the input register into the emitter once it is idle, then
//   eight zero steps, two per cycle, and eight result items, one per cycle while the
//   output does not stall; a bad finish gives a single error item instead.
// A new finish item waits in the input register until the emitter is idle again.
// Reset (rst, synchronous, active high) returns the polymod to one, clears group and
// error state, and empties the input and output registers.
module descriptor_checksum_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tuser,   // [0] op: 0 character, 1 finish
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] checksum_char
  output logic       m_tuser,   // [0] status: 1 invalid character seen
  output logic       m_tlast    // last item of a finish run
);
  import dcs_pkg::*;

  logic       in_valid;
  logic       in_op;
  logic [7:0] in_code;
  logic       consume;
  logic       fin_ready;
  dcs_fin_t   fin;

  // Input register; it refills in the same cycle it drains.
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op   <= s_tuser;
      in_code <= s_tdata;
    end
  end

  // Character lookup and polymod state.
  dcs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_code   (in_code),
    .fin_ready (fin_ready),
    .consume   (consume),
    .fin       (fin)
  );

  // Checksum finish and result output register.
  dcs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .fin_ready (fin_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
